FILE: hw/rtl/dmmh_pkg.sv
// Shared types, codes and helpers for the distributed mutex message handler.
// No dependencies; imported by every RTL module of the block.
package dmmh_pkg;

  // Bitmaps never grow past this many nodes.
  localparam int unsigned BITMAP_LIMIT  = 32;
  localparam int unsigned DEF_MAX_NODES = 32;
  localparam int unsigned DEF_SEQ_BITS  = 32;
  localparam int unsigned DEF_QUEUE_DEPTH = 2;

  // Message kinds.
  localparam logic [1:0] OP_REQUEST = 2'd0;
  localparam logic [1:0] OP_REPLY   = 2'd1;

  // Result status codes.
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_RANGE   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_OWN_INDEX   = 2'd0;
  localparam logic [1:0] REG_NODE_COUNT  = 2'd1;
  localparam logic [1:0] REG_SERVER_MASK = 2'd2;

  // Classification handed from front to back.
  typedef struct packed {
    logic [1:0] status;    // ST_* decided up front
    logic       is_reply;
    logic       our_prio;  // our pending request wins over theirs
    logic       using_cs;
    logic       waiting;
  } cls_t;

  // One result beat.
  typedef struct packed {
    logic        send_reply;
    logic        send_request;
    logic        all_granted;
    logic [1:0]  status;
    logic [31:0] deferred_map;
    logic [31:0] highest_seq;
  } res_t;

  // Node count limited to the bitmap width in use.
  function automatic logic [6:0] eff_count(input logic [5:0] nc, input int unsigned lim);
    logic [6:0] r;
    if (nc > lim) r = 7'(lim);
    else r = {1'b0, nc};
    return r;
  endfunction

endpackage

FILE: hw/rtl/distributed_mutex_message_handler.sv
// Top level of the distributed mutex message handler.
// Depends on dmmh_pkg, dmmh_front, dmmh_back and dmmh_queue.
//
// Message handler for one node of a Roucairol-Carvalho style distributed
// mutex. Each input beat is one lock-protocol message (request or reply)
// plus the node's live using/waiting flags and own sequence number; each
// yields exactly one result beat with the reply/re-request decision, the
// all-granted flag, a status code and the deferred bitmap and highest
// sequence seen after the message. Throughput is one message per clock
// while the result queue is not full: the front end classifies a beat in
// the cycle it is pushed, a 2-entry queue decouples it from the back end,
// which updates the bitmaps and writes a 2-entry result queue. A result
// shows up on the result ports (empty drops) once its message has passed
// the message queue and the back end's push into the result queue. full
// rises only when the back end is held up by a stalled result side. Config
// writes (own_index, node_count, server_mask) are always ready and must
// land only while the block is idle. Node counts above the bitmap width
// are clamped; unknown messages and out-of-range sources return a status
// code and leave state untouched.
module distributed_mutex_message_handler import dmmh_pkg::*; #(
  parameter int unsigned MAX_NODES = DEF_MAX_NODES,
  parameter int unsigned SEQ_BITS  = DEF_SEQ_BITS
) (
  input  logic        clk,
  input  logic        rst,
  // message input queue
  input  logic        push,
  output logic        full,
  input  logic [1:0]  operation,
  input  logic [4:0]  source_node,
  input  logic [31:0] their_seq,
  input  logic        local_using,
  input  logic        local_waiting,
  input  logic [31:0] own_seq,
  // result queue
  output logic        empty,
  input  logic        pop,
  output logic        send_reply,
  output logic        send_request,
  output logic        all_granted,
  output logic [1:0]  status,
  output logic [31:0] deferred_map,
  output logic [31:0] highest_seq,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  // Bitmaps are as wide as the node limit, capped at 32.
  localparam int unsigned MAP_BITS = (MAX_NODES < BITMAP_LIMIT) ? MAX_NODES : BITMAP_LIMIT;
  localparam int unsigned CLS_W    = $bits(cls_t);
  localparam int unsigned MID_W    = CLS_W + MAP_BITS + SEQ_BITS;
  localparam int unsigned RES_W    = $bits(res_t);

  // config registers
  logic [4:0]  own_index;
  logic [5:0]  node_count;
  logic [31:0] server_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_index   <= '0;
      node_count  <= 6'd1;
      server_mask <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OWN_INDEX:   own_index   <= cfg_data[4:0];
        REG_NODE_COUNT:  node_count  <= cfg_data[5:0];
        REG_SERVER_MASK: server_mask <= cfg_data;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // front -> mid queue
  logic                f_wr, mid_full, mid_empty, mid_pop;
  cls_t                f_cls, b_cls;
  logic [MAP_BITS-1:0] f_src_bit, b_src_bit;
  logic [SEQ_BITS-1:0] f_theirs, b_theirs;
  logic [MID_W-1:0]    mid_rd;

  dmmh_front #(.MAP_BITS(MAP_BITS), .SEQ_BITS(SEQ_BITS)) u_front (
    .push          (push),
    .full          (full),
    .operation     (operation),
    .source_node   (source_node),
    .their_seq     (their_seq),
    .local_using   (local_using),
    .local_waiting (local_waiting),
    .own_seq       (own_seq),
    .own_index     (own_index),
    .node_count    (node_count),
    .q_wr          (f_wr),
    .q_full        (mid_full),
    .q_cls         (f_cls),
    .q_src_bit     (f_src_bit),
    .q_theirs      (f_theirs)
  );

  dmmh_queue #(.WIDTH(MID_W), .DEPTH(DEF_QUEUE_DEPTH)) u_mid_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (f_wr),
    .wr_data ({f_cls, f_src_bit, f_theirs}),
    .full    (mid_full),
    .rd_en   (mid_pop),
    .rd_data (mid_rd),
    .empty   (mid_empty)
  );

  assign {b_cls, b_src_bit, b_theirs} = mid_rd;

  // back -> result queue
  logic             res_full, res_push;
  res_t             b_res, o_res;
  logic [RES_W-1:0] res_rd;

  dmmh_back #(.MAP_BITS(MAP_BITS), .SEQ_BITS(SEQ_BITS)) u_back (
    .clk         (clk),
    .rst         (rst),
    .own_index   (own_index),
    .node_count  (node_count),
    .server_mask (server_mask),
    .in_valid    (!mid_empty),
    .in_pop      (mid_pop),
    .in_cls      (b_cls),
    .in_src_bit  (b_src_bit),
    .in_theirs   (b_theirs),
    .out_full    (res_full),
    .out_push    (res_push),
    .out_res     (b_res)
  );

  dmmh_queue #(.WIDTH(RES_W), .DEPTH(DEF_QUEUE_DEPTH)) u_res_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (b_res),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_rd),
    .empty   (empty)
  );

  assign o_res        = res_rd;
  assign send_reply   = o_res.send_reply;
  assign send_request = o_res.send_request;
  assign all_granted  = o_res.all_granted;
  assign status       = o_res.status;
  assign deferred_map = o_res.deferred_map;
  assign highest_seq  = o_res.highest_seq;

`ifndef ASSERT_OFF
  // error results carry no protocol action
  a_err_quiet: assert property (@(posedge clk) disable iff (rst)
    (!empty && (status != ST_OK)) |-> (!send_reply && !send_request && !all_granted))
    else $error("error result carries an action");

  // a re-request always rides with a reply
  a_req_with_reply: assert property (@(posedge clk) disable iff (rst)
    (!empty && send_request) |-> send_reply)
    else $error("re-request without reply");

  // highest sequence seen never moves down
  a_hi_monotonic: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) |-> (u_back.highest_seen >= $past(u_back.highest_seen)))
    else $error("highest sequence decreased");
`endif

endmodule

FILE: hw/rtl/dmmh_queue.sv
// Small register-based FIFO used between the block's stages.
// Depends on dmmh_pkg for its default depth.
module dmmh_queue import dmmh_pkg::*; #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_wr, do_rd;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule

FILE: hw/rtl/dmmh_front.sv
// Front end: takes message beats, decodes kind, range-checks the source
// and settles request priority. Depends on dmmh_pkg.
module dmmh_front import dmmh_pkg::*; #(
  parameter int unsigned MAP_BITS = BITMAP_LIMIT,
  parameter int unsigned SEQ_BITS = DEF_SEQ_BITS
) (
  input  logic                push,
  output logic                full,
  input  logic [1:0]          operation,
  input  logic [4:0]          source_node,
  input  logic [31:0]         their_seq,
  input  logic                local_using,
  input  logic                local_waiting,
  input  logic [31:0]         own_seq,
  input  logic [4:0]          own_index,
  input  logic [5:0]          node_count,
  // queue side
  output logic                q_wr,
  input  logic                q_full,
  output cls_t                q_cls,
  output logic [MAP_BITS-1:0] q_src_bit,
  output logic [SEQ_BITS-1:0] q_theirs
);

  logic [6:0]          n_eff;
  logic [SEQ_BITS-1:0] theirs, ours;

  assign full     = q_full;
  assign q_wr     = push;
  assign n_eff    = eff_count(node_count, MAP_BITS);
  assign theirs   = SEQ_BITS'(their_seq);
  assign ours     = SEQ_BITS'(own_seq);
  assign q_theirs = theirs;

  always_comb begin
    q_cls.is_reply = (operation == OP_REPLY);
    q_cls.using_cs = local_using;
    q_cls.waiting  = local_waiting;
    q_cls.our_prio = (theirs > ours) || ((theirs == ours) && (source_node > own_index));
    // unknown kind wins over a bad source
    if (operation != OP_REQUEST && operation != OP_REPLY) q_cls.status = ST_UNKNOWN;
    else if ({2'b00, source_node} >= n_eff) q_cls.status = ST_RANGE;
    else q_cls.status = ST_OK;
  end

  always_comb begin
    for (int i = 0; i < MAP_BITS; i++) begin
      q_src_bit[i] = (source_node == i);
    end
  end

endmodule

FILE: hw/rtl/dmmh_back.sv
// Back end: applies classified messages to the grant/defer bitmaps and
// highest sequence, and forms result beats. Depends on dmmh_pkg.
module dmmh_back import dmmh_pkg::*; #(
  parameter int unsigned MAP_BITS = BITMAP_LIMIT,
  parameter int unsigned SEQ_BITS = DEF_SEQ_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [4:0]          own_index,
  input  logic [5:0]          node_count,
  input  logic [31:0]         server_mask,
  input  logic                in_valid,
  output logic                in_pop,
  input  cls_t                in_cls,
  input  logic [MAP_BITS-1:0] in_src_bit,
  input  logic [SEQ_BITS-1:0] in_theirs,
  input  logic                out_full,
  output logic                out_push,
  output res_t                out_res
);

  logic [SEQ_BITS-1:0] highest_seen, highest_seen_next;
  logic [MAP_BITS-1:0] granted_map, granted_map_next;
  logic [MAP_BITS-1:0] deferred_bits, deferred_bits_next;
  logic [MAP_BITS-1:0] dont_care;   // self, servers and nodes past the count
  logic [6:0]          n_eff;
  logic                had_grant, reply_plain, reply_again, defer;
  logic                send_reply, send_request, all_granted;

  assign in_pop   = in_valid && !out_full;
  assign out_push = in_pop;
  assign n_eff    = eff_count(node_count, MAP_BITS);

  always_comb begin
    for (int i = 0; i < MAP_BITS; i++) begin
      dont_care[i] = (own_index == i) || server_mask[i] || (i >= n_eff);
    end
  end

  always_comb begin
    highest_seen_next  = highest_seen;
    granted_map_next   = granted_map;
    deferred_bits_next = deferred_bits;
    send_reply   = 1'b0;
    send_request = 1'b0;
    all_granted  = 1'b0;
    had_grant    = |(granted_map & in_src_bit);
    defer        = in_cls.using_cs || (in_cls.waiting && in_cls.our_prio);
    reply_plain  = !(in_cls.using_cs || in_cls.waiting) ||
                   (in_cls.waiting && !had_grant && !in_cls.our_prio);
    reply_again  = in_cls.waiting && had_grant && !in_cls.our_prio;
    if (in_cls.status == ST_OK) begin
      if (!in_cls.is_reply) begin
        if (in_theirs > highest_seen) highest_seen_next = in_theirs;
        if (defer) deferred_bits_next = deferred_bits | in_src_bit;
        if (reply_plain || reply_again) begin
          granted_map_next = granted_map & ~in_src_bit;
          send_reply       = 1'b1;
        end
        send_request = reply_again;
      end else begin
        granted_map_next = granted_map | in_src_bit;
        all_granted      = in_cls.waiting && (&(granted_map_next | dont_care));
      end
    end
  end

  always_comb begin
    out_res.send_reply   = send_reply;
    out_res.send_request = send_request;
    out_res.all_granted  = all_granted;
    out_res.status       = in_cls.status;
    out_res.deferred_map = 32'(deferred_bits_next);
    out_res.highest_seq  = 32'(highest_seen_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      highest_seen  <= '0;
      granted_map   <= '0;
      deferred_bits <= '0;
    end else if (in_pop) begin
      highest_seen  <= highest_seen_next;
      granted_map   <= granted_map_next;
      deferred_bits <= deferred_bits_next;
    end
  end

endmodule
